>>> rtl/assert_macros.svh
// Assertion macros for the checker file.
// No dependencies; included by cds_checker.sv, which carries concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is asserted.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked assertion that also holds during reset.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

>>> rtl/cds_pkg.sv
// Package for the calendar date stepper: widths, codes, microcode types
// and the month length function. No dependencies.
`default_nettype none

package cds_pkg;

    localparam int YEAR_WIDTH  = 16;
    localparam int DELTA_WIDTH = 16;

    localparam logic [YEAR_WIDTH-1:0] YEAR_MAX   = '1;
    localparam logic [YEAR_WIDTH-1:0] YEAR_RESET = YEAR_WIDTH'(1970);

    localparam logic [3:0] MONTH_JAN = 4'd1;
    localparam logic [3:0] MONTH_FEB = 4'd2;
    localparam logic [3:0] MONTH_DEC = 4'd12;
    localparam logic [4:0] DAY_FIRST = 5'd1;
    localparam logic [4:0] DAY_LAST_DEC = 5'd31;
    localparam logic [4:0] DAY_FEB_LEAP = 5'd29;

    localparam logic [4:0] MONTH_LEN [16] = '{
        5'd0, 5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31,
        5'd31, 5'd30, 5'd31, 5'd30, 5'd31, 5'd0, 5'd0, 5'd0
    };

    localparam logic [1:0] CMD_SET  = 2'd0;
    localparam logic [1:0] CMD_ADD  = 2'd1;
    localparam logic [1:0] CMD_READ = 2'd2;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_BAD_MONTH = 2'd1;
    localparam logic [1:0] ST_BAD_DAY   = 2'd2;
    localparam logic [1:0] ST_YEAR_SAT  = 2'd3;

    typedef logic [2:0] upc_t;

    localparam upc_t UA_WAIT    = 3'd0;
    localparam upc_t UA_DECODE  = 3'd1;
    localparam upc_t UA_CHK_ADD = 3'd2;
    localparam upc_t UA_STEP    = 3'd3;
    localparam upc_t UA_SET     = 3'd4;
    localparam upc_t UA_EMIT    = 3'd5;

    typedef enum logic [2:0] {
        OP_NOP,
        OP_CAPTURE,
        OP_STEP,
        OP_SET,
        OP_EMIT
    } op_t;

    typedef enum logic [2:0] {
        COND_ALWAYS,
        COND_TAKEN,
        COND_IS_SET,
        COND_IS_ADD,
        COND_STEP_END
    } cond_t;

    typedef struct packed {
        op_t   op;
        cond_t cond;
        upc_t  jt;
        upc_t  jf;
    } ctrl_t;

    typedef struct packed {
        logic taken;
        logic is_set;
        logic is_add;
        logic step_end;
    } flags_t;

    function automatic logic [4:0] days_in(input logic [YEAR_WIDTH-1:0] year,
                                           input logic [3:0] month);
        logic [4:0] len;
        len = MONTH_LEN[month];
        if (month == MONTH_FEB && year[1:0] == 2'b00)
        begin
            len = DAY_FEB_LEAP;
        end
        return len;
    endfunction

endpackage

`default_nettype wire

>>> rtl/cds_if.sv
// Channel interfaces of the calendar date stepper: command items in,
// date items out. Depends on cds_pkg.
`default_nettype none

interface cds_cmd_if;
    import cds_pkg::*;

    logic                          valid;
    logic                          ready;
    logic [1:0]                    cmd;
    logic [YEAR_WIDTH-1:0]         new_year;
    logic [3:0]                    new_month;
    logic [4:0]                    new_day;
    logic signed [DELTA_WIDTH-1:0] day_delta;

    modport source (output valid, cmd, new_year, new_month, new_day, day_delta,
                    input ready);
    modport sink (input valid, cmd, new_year, new_month, new_day, day_delta,
                  output ready);
endinterface

interface cds_date_if;
    import cds_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [YEAR_WIDTH-1:0] cur_year;
    logic [3:0]            cur_month;
    logic [4:0]            cur_day;
    logic [1:0]            status;

    modport source (output valid, cur_year, cur_month, cur_day, status,
                    input ready);
    modport sink (input valid, cur_year, cur_month, cur_day, status,
                  output ready);
endinterface

`default_nettype wire

>>> rtl/cds_sequencer.sv
// Microcode sequencer: step counter, control store and jump logic.
// Depends on cds_pkg.
`default_nettype none

module cds_sequencer
    import cds_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire flags_t flags,
    output ctrl_t       ctrl
);

    upc_t upc_reg;
    upc_t upc_next;
    logic cond_true;

    function automatic ctrl_t ucode_rom(input upc_t addr);
        ctrl_t w;
        case (addr)
            UA_WAIT:    w = '{op: OP_CAPTURE, cond: COND_TAKEN,
                              jt: UA_DECODE, jf: UA_WAIT};
            UA_DECODE:  w = '{op: OP_NOP, cond: COND_IS_SET,
                              jt: UA_SET, jf: UA_CHK_ADD};
            UA_CHK_ADD: w = '{op: OP_NOP, cond: COND_IS_ADD,
                              jt: UA_STEP, jf: UA_EMIT};
            UA_STEP:    w = '{op: OP_STEP, cond: COND_STEP_END,
                              jt: UA_EMIT, jf: UA_STEP};
            UA_SET:     w = '{op: OP_SET, cond: COND_ALWAYS,
                              jt: UA_EMIT, jf: UA_EMIT};
            UA_EMIT:    w = '{op: OP_EMIT, cond: COND_ALWAYS,
                              jt: UA_WAIT, jf: UA_WAIT};
            default:    w = '{op: OP_NOP, cond: COND_ALWAYS,
                              jt: UA_WAIT, jf: UA_WAIT};
        endcase
        return w;
    endfunction

    assign ctrl = ucode_rom(upc_reg);

    always_comb
    begin
        case (ctrl.cond)
            COND_ALWAYS:   cond_true = 1'b1;
            COND_TAKEN:    cond_true = flags.taken;
            COND_IS_SET:   cond_true = flags.is_set;
            COND_IS_ADD:   cond_true = flags.is_add;
            COND_STEP_END: cond_true = flags.step_end;
            default:       cond_true = 1'b1;
        endcase
        upc_next = cond_true ? ctrl.jt : ctrl.jf;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upc_reg <= UA_WAIT;
        end
        else
        begin
            upc_reg <= upc_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/cds_datapath.sv
// Datapath: command capture, date registers, day step unit, set check
// and the output register. Depends on cds_pkg and cds_if.
`default_nettype none

module cds_datapath
    import cds_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire ctrl_t ctrl,
    output flags_t     flags,
    cds_cmd_if.sink    cmd_ch,
    cds_date_if.source date_ch
);

    logic [YEAR_WIDTH-1:0]  year_reg,  year_next;
    logic [3:0]             month_reg, month_next;
    logic [4:0]             day_reg,   day_next;
    logic                   out_valid_reg, out_valid_next;

    logic [1:0]             cmd_reg;
    logic [YEAR_WIDTH-1:0]  new_year_reg;
    logic [3:0]             new_month_reg;
    logic [4:0]             new_day_reg;
    logic                   neg_reg;
    logic [DELTA_WIDTH-1:0] mag_reg, mag_next;
    logic [1:0]             status_reg, status_next;

    logic [YEAR_WIDTH-1:0]  out_year_reg;
    logic [3:0]             out_month_reg;
    logic [4:0]             out_day_reg;
    logic [1:0]             out_status_reg;

    logic                   accept;
    logic [DELTA_WIDTH-1:0] delta_raw;
    logic [DELTA_WIDTH-1:0] delta_mag;
    logic [4:0]             len_cur;
    logic [4:0]             len_prev;
    logic [4:0]             len_new;
    logic                   step_fail;

    assign cmd_ch.ready = (ctrl.op == OP_CAPTURE) && (!out_valid_reg || date_ch.ready);
    assign accept       = cmd_ch.valid && cmd_ch.ready;

    assign delta_raw = DELTA_WIDTH'(unsigned'(cmd_ch.day_delta));
    assign delta_mag = delta_raw[DELTA_WIDTH-1] ? (~delta_raw + DELTA_WIDTH'(1)) : delta_raw;

    assign len_cur  = days_in(year_reg, month_reg);
    assign len_prev = days_in(year_reg, month_reg - 4'd1);
    assign len_new  = days_in(new_year_reg, new_month_reg);

    assign flags.taken    = accept;
    assign flags.is_set   = (cmd_reg == CMD_SET);
    assign flags.is_add   = (cmd_reg == CMD_ADD);
    assign flags.step_end = (mag_reg[DELTA_WIDTH-1:1] == '0) || step_fail;

    always_comb
    begin
        year_next      = year_reg;
        month_next     = month_reg;
        day_next       = day_reg;
        mag_next       = mag_reg;
        status_next    = status_reg;
        out_valid_next = out_valid_reg;
        step_fail      = 1'b0;

        if (date_ch.valid && date_ch.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (ctrl.op)
            OP_CAPTURE:
            begin
                if (accept)
                begin
                    status_next = ST_OK;
                    mag_next    = delta_mag;
                end
            end
            OP_STEP:
            begin
                if (mag_reg != '0)
                begin
                    if (!neg_reg)
                    begin
                        if (day_reg < len_cur)
                        begin
                            day_next = day_reg + 5'd1;
                        end
                        else if (month_reg < MONTH_DEC)
                        begin
                            month_next = month_reg + 4'd1;
                            day_next   = DAY_FIRST;
                        end
                        else if (year_reg == YEAR_MAX)
                        begin
                            step_fail = 1'b1;
                        end
                        else
                        begin
                            year_next  = year_reg + YEAR_WIDTH'(1);
                            month_next = MONTH_JAN;
                            day_next   = DAY_FIRST;
                        end
                    end
                    else
                    begin
                        if (day_reg > DAY_FIRST)
                        begin
                            day_next = day_reg - 5'd1;
                        end
                        else if (month_reg > MONTH_JAN)
                        begin
                            month_next = month_reg - 4'd1;
                            day_next   = len_prev;
                        end
                        else if (year_reg == '0)
                        begin
                            step_fail = 1'b1;
                        end
                        else
                        begin
                            year_next  = year_reg - YEAR_WIDTH'(1);
                            month_next = MONTH_DEC;
                            day_next   = DAY_LAST_DEC;
                        end
                    end

                    if (step_fail)
                    begin
                        status_next = ST_YEAR_SAT;
                        mag_next    = '0;
                    end
                    else
                    begin
                        mag_next = mag_reg - DELTA_WIDTH'(1);
                    end
                end
            end
            OP_SET:
            begin
                if (!(new_month_reg inside {[MONTH_JAN:MONTH_DEC]}))
                begin
                    status_next = ST_BAD_MONTH;
                end
                else if (new_day_reg == 5'd0 || new_day_reg > len_new)
                begin
                    status_next = ST_BAD_DAY;
                end
                else
                begin
                    year_next  = new_year_reg;
                    month_next = new_month_reg;
                    day_next   = new_day_reg;
                end
            end
            OP_EMIT:
            begin
                out_valid_next = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            year_reg      <= YEAR_RESET;
            month_reg     <= MONTH_JAN;
            day_reg       <= DAY_FIRST;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            year_reg      <= year_next;
            month_reg     <= month_next;
            day_reg       <= day_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        mag_reg    <= mag_next;
        if (accept)
        begin
            cmd_reg       <= cmd_ch.cmd;
            new_year_reg  <= cmd_ch.new_year;
            new_month_reg <= cmd_ch.new_month;
            new_day_reg   <= cmd_ch.new_day;
            neg_reg       <= delta_raw[DELTA_WIDTH-1];
        end
        if (ctrl.op == OP_EMIT)
        begin
            out_year_reg   <= year_reg;
            out_month_reg  <= month_reg;
            out_day_reg    <= day_reg;
            out_status_reg <= status_reg;
        end
    end

    assign date_ch.valid     = out_valid_reg;
    assign date_ch.cur_year  = out_year_reg;
    assign date_ch.cur_month = out_month_reg;
    assign date_ch.cur_day   = out_day_reg;
    assign date_ch.status    = out_status_reg;

endmodule

`default_nettype wire

>>> rtl/calendar_date_stepper.sv
// Top level of the calendar date stepper: microcode sequencer plus datapath.
// Depends on cds_pkg, cds_if, cds_sequencer and cds_datapath.
//
// Usage:
//   cmd_ch takes one command item: set date, add a signed day count, or read.
//   date_ch returns exactly one item per command: the stored date after the
//   command and a status (ok, bad month, bad day, year saturated).
//   A rejected set leaves the date unchanged; a saturating add holds the date
//   at the year limit and drops the remaining days.
// Program steps after a command is taken: decode, then set (set) or the add
//   check (add, read), then the step loop for an add, then emit to date_ch.
//   The add loop moves the date one day per cycle through one step unit, so
//   an add of N days (N up to 32768) keeps the block busy for all N steps.
// One command is in flight at a time; cmd_ch.ready is high only at the wait
//   step of the program, and only when the output register is empty or being
//   drained in the same cycle.
// Reset loads 1970-01-01, clears the output register and restarts the program.
// A stalled date_ch holds its item; no new command is taken until it drains.
`default_nettype none

module calendar_date_stepper
    import cds_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    cds_cmd_if.sink    cmd_ch,
    cds_date_if.source date_ch
);

    ctrl_t  ctrl;
    flags_t flags;

    cds_sequencer u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .flags (flags),
        .ctrl  (ctrl)
    );

    cds_datapath u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (ctrl),
        .flags   (flags),
        .cmd_ch  (cmd_ch),
        .date_ch (date_ch)
    );

endmodule

`default_nettype wire

>>> rtl/cds_checker.sv
// Port-level checker for the calendar date stepper and its bind.
// Depends on cds_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module cds_checker
    import cds_pkg::*;
(
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       in_valid,
    input wire logic       in_ready,
    input wire logic       out_valid,
    input wire logic       out_ready,
    input wire logic [3:0] cur_month,
    input wire logic [4:0] cur_day
);

    logic in_accept;

    assign in_accept = in_valid && in_ready;

    `ASSERT_CLK(a_month_range, clk, rst_n, out_valid |-> (cur_month >= MONTH_JAN && cur_month <= MONTH_DEC), "month out of range")
    `ASSERT_CLK(a_day_nonzero, clk, rst_n, out_valid |-> (cur_day != 5'd0), "day is zero")
    `ASSERT_CLK(a_no_take_on_stall, clk, rst_n, (out_valid && !out_ready) |-> !in_accept, "command taken while result stalled")
    `ASSERT_CLK(a_no_instant_result, clk, rst_n, in_accept |=> !out_valid, "result appeared right after accept")

endmodule

bind calendar_date_stepper cds_checker u_cds_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (cmd_ch.valid),
    .in_ready  (cmd_ch.ready),
    .out_valid (date_ch.valid),
    .out_ready (date_ch.ready),
    .cur_month (date_ch.cur_month),
    .cur_day   (date_ch.cur_day)
);

`default_nettype wire
